>>> rtl/core/arpp_pkg.sv
// Shared types, constants and codes of the address conflict probe engine.
package arpp_pkg;

  localparam int TIMER_BITS  = 20;
  localparam int JITTER_BITS = 16;

  // Fixed field widths.
  localparam int TICK_W   = 20;
  localparam int MAC_W    = 48;
  localparam int IP_W     = 32;
  localparam int JIT_W    = 16;
  localparam int CFG_W    = 48;
  localparam int CFG_IDX_W = 3;

  // Jitter bits that survive the mask.
  localparam int JIT_EFF = (JITTER_BITS < JIT_W) ? JITTER_BITS : JIT_W;
  localparam logic [63:0] TIMER_MAX = (64'd1 << TIMER_BITS) - 64'd1;

  // Request codes.
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_PKT   = 2'd1;
  localparam logic [1:0] FUNC_START = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_IP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_COUNT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_WAIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_MIN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_MAX     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ANNOUNCE_WAIT = 3'd6;

  // Packet validation constants.
  localparam logic [15:0] HW_TYPE_ETH = 16'h0001;
  localparam logic [15:0] PROTO_IPV4  = 16'h0800;
  localparam logic [7:0]  HW_LEN_ETH  = 8'd6;
  localparam logic [7:0]  PLEN_IPV4   = 8'd4;
  localparam logic [15:0] OP_REQUEST  = 16'd1;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_PROBING   = 2'd1,
    PH_RESERVING = 2'd2,
    PH_CONFLICT  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_PROBE    = 2'd1,
    EV_READY    = 2'd2,
    EV_CONFLICT = 2'd3
  } event_t;

  // The ARP addresses keep their usual short names: sender hardware and
  // protocol address (sha, spa), target hardware and protocol address (tha, tpa).
  typedef struct packed {
    logic [1:0]       func;
    logic [15:0]      hw_type;
    logic [15:0]      proto_type;
    logic [7:0]       hw_len;
    logic [7:0]       plen;
    logic [15:0]      op_code;
    logic [MAC_W-1:0] sha;
    logic [IP_W-1:0]  spa;
    logic [MAC_W-1:0] tha;
    logic [IP_W-1:0]  tpa;
    logic [JIT_W-1:0] jitter;
  } req_t;

  typedef struct packed {
    logic [1:0]       event_res;
    logic [1:0]       phase;
    logic [MAC_W-1:0] conflict_mac;
  } res_t;

endpackage

>>> rtl/core/arpp_req_if.sv
// Request channel of the probe engine: valid, ready and one request item.
interface arpp_req_if import arpp_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/arpp_res_if.sv
// Result channel of the probe engine: valid, ready and one result item.
interface arpp_res_if import arpp_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/arp_address_probe.sv
// Address conflict probe engine: input register, state update and result register.
//
// Channels: req carries ticks, received ARP packets and start requests; res
// returns exactly one result per request (event, phase after the request and
// the conflicting MAC). Configuration is written through cfg_we, cfg_index and
// cfg_wdata, one register per cycle; the user must write it only while no
// request is in flight, as the block itself does not enforce this.
// A request passes the input register, then the result register, before res.
// Throughput: one request per cycle while res is taken. The timer decrement,
// the packet compares and the single jitter multiply (20 x 16 bits) all sit
// between the input register and the result register, so each request sees
// the state left by the one before it without a bubble.
// Reset: configuration returns to its defaults, the engine goes idle with the
// timer stopped and both pipeline registers empty.
// Stall: while res is not taken, the result register holds; one more request
// can wait in the input register, after which req.ready drops.
module arp_address_probe import arpp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  arpp_req_if.sink             req,
  arpp_res_if.source           res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  // Configuration registers.
  logic [MAC_W-1:0]  own_mac;
  logic [IP_W-1:0]   probe_ip;
  logic [7:0]        probe_count;
  logic [TICK_W-1:0] probe_wait_ticks;
  logic [TICK_W-1:0] probe_min_ticks;
  logic [TICK_W-1:0] probe_max_ticks;
  logic [TICK_W-1:0] announce_wait_ticks;

  // Engine state.
  phase_t                probe_phase, probe_phase_next;
  logic [7:0]            tries_left, tries_left_next;
  logic [TIMER_BITS-1:0] countdown, countdown_next;
  logic                  timer_running, timer_running_next;

  // Pipeline registers.
  logic in_valid;
  req_t in_req;
  logic out_valid;
  res_t out_res;
  logic move;

  // Jitter datapath.
  logic                      is_start;
  logic [TICK_W-1:0]         jit_lo, jit_hi, span;
  logic [JIT_EFF-1:0]        jit_frac;
  logic [TICK_W+JIT_EFF-1:0] jit_prod;
  logic [TICK_W-1:0]         jit_val;

  // Packet checks.
  logic pkt_ok, pkt_active, pkt_hit;

  event_t           ev;
  logic [MAC_W-1:0] cmac;

  function automatic logic [TIMER_BITS-1:0] sat_ticks(input logic [TICK_W-1:0] ticks);
    if (64'(ticks) > TIMER_MAX) begin
      return TIMER_BITS'(TIMER_MAX);
    end
    return TIMER_BITS'(ticks);
  endfunction

  assign move      = in_valid && (!out_valid || res.ready);
  assign req.ready = !in_valid || move;
  assign res.valid = out_valid;
  assign res.data  = out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_mac             <= '0;
      probe_ip            <= '0;
      probe_count         <= 8'd3;
      probe_wait_ticks    <= TICK_W'(1000);
      probe_min_ticks     <= TICK_W'(1000);
      probe_max_ticks     <= TICK_W'(2000);
      announce_wait_ticks <= TICK_W'(2000);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OWN_MAC:       own_mac             <= cfg_wdata[MAC_W-1:0];
        CFG_PROBE_IP:      probe_ip            <= cfg_wdata[IP_W-1:0];
        CFG_PROBE_COUNT:   probe_count         <= cfg_wdata[7:0];
        CFG_PROBE_WAIT:    probe_wait_ticks    <= cfg_wdata[TICK_W-1:0];
        CFG_PROBE_MIN:     probe_min_ticks     <= cfg_wdata[TICK_W-1:0];
        CFG_PROBE_MAX:     probe_max_ticks     <= cfg_wdata[TICK_W-1:0];
        CFG_ANNOUNCE_WAIT: announce_wait_ticks <= cfg_wdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // A start waits from zero up to the probe wait; every other jittered gap runs
  // from the minimum to the maximum. Only one of them occurs per request.
  assign is_start = in_req.func == FUNC_START;
  assign jit_lo   = is_start ? '0 : probe_min_ticks;
  assign jit_hi   = is_start ? probe_wait_ticks : probe_max_ticks;
  assign span     = (jit_hi > jit_lo) ? jit_hi - jit_lo : '0;
  assign jit_frac = in_req.jitter[JIT_EFF-1:0];
  assign jit_prod = (TICK_W+JIT_EFF)'(span) * (TICK_W+JIT_EFF)'(jit_frac);
  assign jit_val  = jit_lo + TICK_W'(jit_prod >> JITTER_BITS);

  assign pkt_ok = in_req.hw_type == HW_TYPE_ETH && in_req.proto_type == PROTO_IPV4 &&
                  in_req.hw_len == HW_LEN_ETH && in_req.plen == PLEN_IPV4;
  assign pkt_active = probe_phase == PH_PROBING || probe_phase == PH_RESERVING;
  assign pkt_hit = in_req.spa == probe_ip ||
                   (in_req.tpa == probe_ip && in_req.op_code == OP_REQUEST &&
                    in_req.spa == '0);

  always_comb begin
    probe_phase_next   = probe_phase;
    tries_left_next    = tries_left;
    countdown_next     = countdown;
    timer_running_next = timer_running;
    ev                 = EV_NONE;
    cmac               = '0;
    unique case (in_req.func)
      FUNC_START: begin
        probe_phase_next   = PH_PROBING;
        tries_left_next    = probe_count;
        countdown_next     = sat_ticks(jit_val);
        timer_running_next = 1'b1;
      end
      FUNC_TICK: begin
        if (timer_running) begin
          if (countdown <= TIMER_BITS'(1)) begin
            // Expiry stops the timer; the arms below re-arm it.
            countdown_next     = '0;
            timer_running_next = 1'b0;
            if (probe_phase == PH_RESERVING) begin
              countdown_next     = sat_ticks(jit_val);
              timer_running_next = 1'b1;
              ev                 = EV_PROBE;
            end else if (probe_phase == PH_PROBING) begin
              timer_running_next = 1'b1;
              if (tries_left == '0) begin
                probe_phase_next = PH_RESERVING;
                ev               = EV_READY;
              end else begin
                tries_left_next = tries_left - 8'd1;
                ev              = EV_PROBE;
                if (tries_left == 8'd1) begin
                  countdown_next = sat_ticks(announce_wait_ticks);
                end else begin
                  countdown_next = sat_ticks(jit_val);
                end
              end
            end
          end else begin
            countdown_next = countdown - TIMER_BITS'(1);
          end
        end
      end
      FUNC_PKT: begin
        if (pkt_ok && pkt_active && in_req.sha != own_mac && pkt_hit) begin
          probe_phase_next   = PH_CONFLICT;
          countdown_next     = '0;
          timer_running_next = 1'b0;
          ev                 = EV_CONFLICT;
          cmac               = in_req.sha;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      out_valid     <= 1'b0;
      probe_phase   <= PH_IDLE;
      tries_left    <= '0;
      countdown     <= '0;
      timer_running <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        in_valid <= 1'b1;
      end else if (move) begin
        in_valid <= 1'b0;
      end
      if (move) begin
        out_valid     <= 1'b1;
        probe_phase   <= probe_phase_next;
        tries_left    <= tries_left_next;
        countdown     <= countdown_next;
        timer_running <= timer_running_next;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_req <= req.data;
    end
    if (move) begin
      out_res.event_res    <= ev;
      out_res.phase        <= probe_phase_next;
      out_res.conflict_mac <= cmac;
    end
  end

`ifndef NO_ASSERTIONS
  a_timer_stopped_clear: assert property (@(posedge clk) disable iff (rst)
    !timer_running |-> countdown == '0)
    else $error("stopped timer holds a nonzero count");

  a_conflict_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.event_res == EV_CONFLICT |-> out_res.phase == PH_CONFLICT)
    else $error("conflict reported outside the conflict phase");

  a_mac_only_on_conflict: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.event_res != EV_CONFLICT |-> out_res.conflict_mac == '0)
    else $error("conflict MAC reported without a conflict");

  a_ready_reserving: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.event_res == EV_READY |-> out_res.phase == PH_RESERVING)
    else $error("ready reported outside the reserving phase");

  a_idle_timer_off: assert property (@(posedge clk) disable iff (rst)
    probe_phase == PH_IDLE |-> !timer_running)
    else $error("timer running while idle");
`endif

endmodule

>>> tb/arp_address_probe_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the address conflict probe engine with its own predictor.
module arp_address_probe_tb import arpp_pkg::*; ();

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_ITEMS    = 69;
  // The package leaves the fourth request code unnamed; the engine ignores it.
  localparam logic [1:0]  FUNC_SPARE = 2'd3;
  localparam logic [15:0] OP_REPLY   = 16'd2;

  typedef struct {
    logic [MAC_W-1:0]  own_mac;
    logic [IP_W-1:0]   probe_ip;
    logic [7:0]        probe_count;
    logic [TICK_W-1:0] wait_ticks;
    logic [TICK_W-1:0] min_ticks;
    logic [TICK_W-1:0] max_ticks;
    logic [TICK_W-1:0] announce_ticks;
  } settings_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  arpp_req_if req_ch ();
  arpp_res_if res_ch ();

  arp_address_probe dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predicted engine: configuration copy and state.
  settings_t         eng_cfg;
  phase_t            eng_phase;
  logic [7:0]        eng_tries;
  logic [TICK_W-1:0] eng_countdown;
  logic              eng_running;

  res_t expected_results[$];
  int   mismatches     = 0;
  int   stalled_cycles = 0;
  bit   no_idle        = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] scaled_wait(logic [TICK_W-1:0] lo, logic [TICK_W-1:0] hi,
                                               logic [JIT_W-1:0] jit);
    logic [63:0] span;
    logic [63:0] frac;
    span = (hi > lo) ? 64'(hi - lo) : 64'd0;
    frac = 64'(jit) & ((64'd1 << JITTER_BITS) - 64'd1);
    return 64'(lo) + ((span * frac) >> JITTER_BITS);
  endfunction

  function automatic void arm_timer(logic [63:0] ticks);
    eng_countdown = (ticks > TIMER_MAX) ? TICK_W'(TIMER_MAX) : TICK_W'(ticks);
    eng_running   = 1'b1;
  endfunction

  function automatic event_t timer_expired(logic [JIT_W-1:0] jit);
    eng_countdown = '0;
    eng_running   = 1'b0;
    if (eng_phase == PH_RESERVING) begin
      arm_timer(scaled_wait(eng_cfg.min_ticks, eng_cfg.max_ticks, jit));
      return EV_PROBE;
    end
    if (eng_phase != PH_PROBING) return EV_NONE;
    if (eng_tries == 8'd0) begin
      eng_phase = PH_RESERVING;
      arm_timer(64'd0);
      return EV_READY;
    end
    eng_tries--;
    if (eng_tries == 8'd0) arm_timer(64'(eng_cfg.announce_ticks));
    else arm_timer(scaled_wait(eng_cfg.min_ticks, eng_cfg.max_ticks, jit));
    return EV_PROBE;
  endfunction

  // Applies one request to the predicted engine and returns the result it must produce.
  function automatic res_t advance_engine(req_t r);
    res_t out;
    logic well_formed;
    logic active;
    logic from_hit;
    logic to_hit;
    out = '0;
    out.event_res = EV_NONE;
    case (r.func)
      FUNC_START: begin
        eng_phase = PH_PROBING;
        eng_tries = eng_cfg.probe_count;
        arm_timer(scaled_wait('0, eng_cfg.wait_ticks, r.jitter));
      end
      FUNC_TICK: begin
        if (eng_running) begin
          if (eng_countdown <= 1) out.event_res = timer_expired(r.jitter);
          else eng_countdown--;
        end
      end
      FUNC_PKT: begin
        well_formed = r.hw_type == HW_TYPE_ETH && r.proto_type == PROTO_IPV4 &&
                      r.hw_len == HW_LEN_ETH && r.plen == PLEN_IPV4;
        active = eng_phase == PH_PROBING || eng_phase == PH_RESERVING;
        if (well_formed && active && r.sha != eng_cfg.own_mac) begin
          from_hit = r.spa == eng_cfg.probe_ip;
          to_hit   = r.tpa == eng_cfg.probe_ip && r.op_code == OP_REQUEST &&
                     r.spa == '0;
          if (from_hit || to_hit) begin
            eng_phase         = PH_CONFLICT;
            eng_countdown     = '0;
            eng_running       = 1'b0;
            out.event_res     = EV_CONFLICT;
            out.conflict_mac  = r.sha;
          end
        end
      end
      default: ;
    endcase
    out.phase = eng_phase;
    return out;
  endfunction

  function automatic int pick_gap();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [MAC_W-1:0] random_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic req_t random_req(logic [1:0] f);
    req_t r;
    r.func       = f;
    r.hw_type    = 16'($urandom);
    r.proto_type = 16'($urandom);
    r.hw_len     = 8'($urandom);
    r.plen       = 8'($urandom);
    r.op_code    = 16'($urandom);
    r.sha        = random_mac();
    r.spa        = 32'($urandom);
    r.tha        = random_mac();
    r.tpa        = 32'($urandom);
    r.jitter     = 16'($urandom);
    return r;
  endfunction

  function automatic req_t timer_req(logic [1:0] f, logic [JIT_W-1:0] jit);
    req_t r;
    r = random_req(f);
    r.jitter = jit;
    return r;
  endfunction

  function automatic req_t arp_packet(logic [15:0] op, logic [MAC_W-1:0] smac,
                                      logic [IP_W-1:0] sip, logic [IP_W-1:0] tip);
    req_t r;
    r = random_req(FUNC_PKT);
    r.hw_type    = HW_TYPE_ETH;
    r.proto_type = PROTO_IPV4;
    r.hw_len     = HW_LEN_ETH;
    r.plen       = PLEN_IPV4;
    r.op_code    = op;
    r.sha        = smac;
    r.spa        = sip;
    r.tpa        = tip;
    return r;
  endfunction

  task automatic send_request(req_t r);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    expected_results.push_back(advance_engine(r));
  endtask

  task automatic drain_engine();
    req_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      CFG_OWN_MAC:       eng_cfg.own_mac        = value[MAC_W-1:0];
      CFG_PROBE_IP:      eng_cfg.probe_ip       = value[IP_W-1:0];
      CFG_PROBE_COUNT:   eng_cfg.probe_count    = value[7:0];
      CFG_PROBE_WAIT:    eng_cfg.wait_ticks     = value[TICK_W-1:0];
      CFG_PROBE_MIN:     eng_cfg.min_ticks      = value[TICK_W-1:0];
      CFG_PROBE_MAX:     eng_cfg.max_ticks      = value[TICK_W-1:0];
      CFG_ANNOUNCE_WAIT: eng_cfg.announce_ticks = value[TICK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(settings_t s);
    drain_engine();
    write_reg(CFG_OWN_MAC, CFG_W'(s.own_mac));
    write_reg(CFG_PROBE_IP, CFG_W'(s.probe_ip));
    write_reg(CFG_PROBE_COUNT, CFG_W'(s.probe_count));
    write_reg(CFG_PROBE_WAIT, CFG_W'(s.wait_ticks));
    write_reg(CFG_PROBE_MIN, CFG_W'(s.min_ticks));
    write_reg(CFG_PROBE_MAX, CFG_W'(s.max_ticks));
    write_reg(CFG_ANNOUNCE_WAIT, CFG_W'(s.announce_ticks));
    cfg_we <= 1'b0;
  endtask

  // Tick, spare and packet requests while idle, under the reset configuration.
  task automatic test_idle_requests();
    req_t r;
    send_request(timer_req(FUNC_TICK, '0));
    r = '1;
    r.func = FUNC_SPARE;
    send_request(r);
    r.func = FUNC_PKT;
    send_request(r);
    send_request(arp_packet(OP_REQUEST, '1, '0, '0));
  endtask

  // A full probe series through the ready event into reserving.
  task automatic test_probe_cycle();
    load_settings('{own_mac: 48'h0000_1111_2222, probe_ip: 32'hC0A8_0001, probe_count: 8'd2,
                    wait_ticks: 20'd3, min_ticks: 20'd1, max_ticks: 20'd3,
                    announce_ticks: 20'd2});
    send_request(timer_req(FUNC_START, 16'hFFFF));
    for (int i = 0; i < 9; i++) send_request(timer_req(FUNC_TICK, (i % 2) ? 16'hFFFF : 16'h0));
  endtask

  // A zero wait expires on the next tick; inverted gap bounds fall back to the minimum.
  task automatic test_timer_edges();
    load_settings('{own_mac: 48'h0, probe_ip: 32'h0A00_0005, probe_count: 8'd0,
                    wait_ticks: 20'd0, min_ticks: 20'd4, max_ticks: 20'd1,
                    announce_ticks: 20'd0});
    send_request(timer_req(FUNC_START, 16'hFFFF));
    send_request(timer_req(FUNC_TICK, 16'hFFFF));
    send_request(timer_req(FUNC_TICK, 16'hFFFF));
  endtask

  // Packets that must be ignored, a foreign probe, and a restart out of conflict.
  task automatic test_packet_filters();
    req_t r;
    logic [MAC_W-1:0] peer;
    peer = 48'hAABB_CCDD_EEFF;
    load_settings('{own_mac: 48'h0200_0000_0001, probe_ip: 32'hA9FE_0102, probe_count: 8'd1,
                    wait_ticks: 20'd2, min_ticks: 20'd1, max_ticks: 20'd2,
                    announce_ticks: 20'd3});
    send_request(timer_req(FUNC_START, 16'h8000));
    r = arp_packet(OP_REPLY, peer, eng_cfg.probe_ip, '0);
    r.hw_type = 16'h0002;
    send_request(r);
    r = arp_packet(OP_REPLY, peer, eng_cfg.probe_ip, '0);
    r.proto_type = 16'h86DD;
    send_request(r);
    r = arp_packet(OP_REPLY, peer, eng_cfg.probe_ip, '0);
    r.hw_len = 8'd8;
    send_request(r);
    r = arp_packet(OP_REPLY, peer, eng_cfg.probe_ip, '0);
    r.plen = 8'd16;
    send_request(r);
    send_request(arp_packet(OP_REPLY, eng_cfg.own_mac, eng_cfg.probe_ip, '0));
    send_request(arp_packet(OP_REPLY, peer, '0, eng_cfg.probe_ip));
    send_request(arp_packet(OP_REQUEST, peer, '0, eng_cfg.probe_ip));
    send_request(arp_packet(OP_REPLY, peer, eng_cfg.probe_ip, '0));
    send_request(timer_req(FUNC_TICK, '0));
    send_request(timer_req(FUNC_START, '0));
  endtask

  task automatic test_setting_extremes();
    load_settings('{own_mac: '1, probe_ip: '1, probe_count: '1, wait_ticks: '1,
                    min_ticks: '1, max_ticks: '1, announce_ticks: '1});
    send_request(timer_req(FUNC_START, '0));
    send_request(timer_req(FUNC_TICK, 16'hFFFF));
    send_request(timer_req(FUNC_TICK, 16'hFFFF));
  endtask

  function automatic settings_t random_settings();
    settings_t s;
    s.own_mac        = random_mac();
    s.probe_ip       = 32'($urandom);
    s.probe_count    = 8'($urandom_range(0, 4));
    s.wait_ticks     = 20'($urandom_range(0, 8));
    s.min_ticks      = 20'($urandom_range(0, 5));
    s.max_ticks      = 20'($urandom_range(0, 8));
    s.announce_ticks = 20'($urandom_range(0, 6));
    return s;
  endfunction

  // Mostly ticks, with well-formed packets of every flavor and some noise.
  function automatic req_t random_traffic_item();
    req_t r;
    int roll;
    roll = $urandom_range(0, 99);
    if (eng_phase == PH_CONFLICT && $urandom_range(0, 3) == 0) roll = 70;
    if (roll < 70) return timer_req(FUNC_TICK, 16'($urandom));
    if (roll < 75) return timer_req(FUNC_START, 16'($urandom));
    if (roll < 77) return random_req(FUNC_SPARE);
    if (roll < 85) return arp_packet(16'($urandom_range(1, 2)), random_mac(), 32'($urandom),
                                     32'($urandom));
    if (roll < 88) begin
      r = arp_packet(OP_REQUEST, random_mac(), eng_cfg.probe_ip, eng_cfg.probe_ip);
      case ($urandom_range(0, 3))
        0: r.hw_type    = 16'($urandom_range(2, 65535));
        1: r.proto_type = 16'($urandom_range(0, 16'h07FF));
        2: r.hw_len     = 8'($urandom_range(7, 255));
        default: r.plen = 8'($urandom_range(0, 3));
      endcase
      return r;
    end
    if (roll < 91) return arp_packet(OP_REQUEST, eng_cfg.own_mac, eng_cfg.probe_ip, '0);
    if (roll < 93) return random_req(FUNC_PKT);
    if (roll < 95) return arp_packet(($urandom_range(0, 1)) ? OP_REPLY : OP_REQUEST,
                                     random_mac(), 32'($urandom_range(1, 255)),
                                     eng_cfg.probe_ip);
    if (roll < 97) return arp_packet(16'($urandom_range(1, 2)), random_mac(),
                                     eng_cfg.probe_ip, 32'($urandom));
    return arp_packet(OP_REQUEST, random_mac(), '0, eng_cfg.probe_ip);
  endfunction

  task automatic test_random_traffic();
    settings_t s;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      s = random_settings();
      if (p == 4) s = '{default: '0};
      load_settings(s);
      no_idle = (p % 4 == 1);
      send_request(timer_req(FUNC_START, 16'($urandom)));
      repeat (PHASE_ITEMS) send_request(random_traffic_item());
    end
    no_idle = 1'b0;
  endtask

  // Result receiver: bursts of ready with stalls of random length in between.
  initial begin
    int stall;
    int burst;
    res_ch.ready <= 1'b0;
    forever begin
      stall = pick_gap();
      burst = $urandom_range(1, 24);
      repeat (stall) begin
        res_ch.ready <= 1'b0;
        @(posedge clk);
      end
      repeat (burst) begin
        res_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_result
    res_t want;
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        $error("result arrived with no request pending");
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (res_ch.data.event_res !== want.event_res) begin
          $error("event_res: expected %0d, got %0d", want.event_res, res_ch.data.event_res);
          mismatches++;
        end
        if (res_ch.data.phase !== want.phase) begin
          $error("phase: expected %0d, got %0d", want.phase, res_ch.data.phase);
          mismatches++;
        end
        if (res_ch.data.conflict_mac !== want.conflict_mac) begin
          $error("conflict_mac: expected %h, got %h", want.conflict_mac,
                 res_ch.data.conflict_mac);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
      stalled_cycles <= 0;
    else
      stalled_cycles <= stalled_cycles + 1;
    if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_index    <= '0;
    cfg_wdata    <= '0;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    eng_cfg       = '{own_mac: '0, probe_ip: '0, probe_count: 8'd3, wait_ticks: 20'd1000,
                      min_ticks: 20'd1000, max_ticks: 20'd2000, announce_ticks: 20'd2000};
    eng_phase     = PH_IDLE;
    eng_tries     = '0;
    eng_countdown = '0;
    eng_running   = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_idle_requests();
    test_probe_cycle();
    test_timer_edges();
    test_packet_filters();
    test_setting_extremes();
    test_random_traffic();
    drain_engine();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
